>>> rtl/core/mpr_pkg.sv
// ----------------------------------------------------------------------------
// mpr_pkg
// shared types, codes and constants of the marker framed packet receiver
// ----------------------------------------------------------------------------
`default_nettype none

package mpr_pkg;

  localparam int PAYLOAD_MAX_DEF = 64;

  localparam logic [7:0] START_RST = 8'hAA;
  localparam logic [7:0] END_RST   = 8'h55;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_END   = 1'b1;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_CSUM = 2'd1;
  localparam status_t ST_LEN  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_CMD    = 3'd1,
    PH_LEN    = 3'd2,
    PH_DATA   = 3'd3,
    PH_CSUM   = 3'd4,
    PH_END    = 3'd5,
    PH_REPLAY = 3'd6
  } phase_t;

  typedef struct packed {
    logic    load_cmd;
    logic    load_len;
    logic    store_data;
    logic    load_csum;
    logic    end_clear;
    logic    emit;
    status_t emit_status;
    logic    rep_issue;
    logic    rep_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_match;
    logic end_match;
    logic len_over;
    logic len_zero;
    logic in_zero;
    logic data_last;
    logic sum_ok;
    logic rep_more;
    logic pend;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/mpr_ctrl.sv
// ----------------------------------------------------------------------------
// mpr_ctrl
// frame phase state machine, issues commands to the datapath
// ----------------------------------------------------------------------------
`default_nettype none

module mpr_ctrl
  import mpr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire dp_stat_t  stat,
  output ctrl_cmd_t      cmd
);

  phase_t phase_r;
  phase_t phase_nxt;
  logic   fire;

  assign fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: begin
        if (fire && stat.start_match) phase_nxt = PH_CMD;
      end
      PH_CMD: begin
        if (fire) phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        if (fire) begin
          if (stat.len_over) phase_nxt = PH_IDLE;
          else if (stat.in_zero) phase_nxt = PH_CSUM;
          else phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (fire && stat.data_last) phase_nxt = PH_CSUM;
      end
      PH_CSUM: begin
        if (fire) phase_nxt = PH_END;
      end
      PH_END: begin
        if (fire) begin
          if (stat.end_match && stat.sum_ok && !stat.len_zero) phase_nxt = PH_REPLAY;
          else phase_nxt = PH_IDLE;
        end
      end
      PH_REPLAY: begin
        if (!stat.rep_more && !stat.pend) phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = (fire && stat.start_match) ? PH_CMD : PH_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        in_tready = 1'b1;
      end
      PH_CMD: begin
        in_tready    = 1'b1;
        cmd.load_cmd = fire;
      end
      PH_LEN: begin
        in_tready       = stat.out_free;
        cmd.load_len    = fire;
        cmd.emit        = fire && stat.len_over;
        cmd.emit_status = ST_LEN;
      end
      PH_DATA: begin
        in_tready      = 1'b1;
        cmd.store_data = fire;
      end
      PH_CSUM: begin
        in_tready     = 1'b1;
        cmd.load_csum = fire;
      end
      PH_END: begin
        in_tready       = stat.out_free;
        cmd.end_clear   = fire;
        cmd.emit        = fire && stat.end_match && (!stat.sum_ok || stat.len_zero);
        cmd.emit_status = stat.sum_ok ? ST_OK : ST_CSUM;
      end
      PH_REPLAY: begin
        cmd.rep_load  = stat.pend && stat.out_free;
        cmd.rep_issue = stat.rep_more && (!stat.pend || stat.out_free);
      end
      default: begin
        in_tready = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/mpr_dp.sv
// ----------------------------------------------------------------------------
// mpr_dp
// frame registers, payload memory, checksum and result register
// ----------------------------------------------------------------------------
`default_nettype none

module mpr_dp
  import mpr_pkg::*;
#(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_byte,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  input  wire ctrl_cmd_t   cmd,
  output dp_stat_t         stat,
  input  wire logic        out_tready,
  output logic             out_valid,
  output status_t          out_status,
  output logic [7:0]       out_command,
  output logic [7:0]       out_length,
  output logic             out_has_payload,
  output logic [7:0]       out_payload,
  output logic [5:0]       out_index,
  output logic             out_last
);

  localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam logic [8:0] MAX9 = 9'(PAYLOAD_MAX);

  logic [7:0] start_r, end_r;
  logic [7:0] cmd_r, count_r, idx_r, sum_r, csum_r;
  logic [7:0] idx_nxt, sum_nxt;
  logic [7:0] mem [PAYLOAD_MAX];
  logic [7:0] rdata_r;
  logic [7:0] pidx_r;
  logic       pend_r, pend_nxt;
  logic       ov_r, ov_nxt;
  status_t    ost_r;
  logic [7:0] ocmd_r, olen_r, opb_r;
  logic [5:0] oidx_r;
  logic       ohp_r, olast_r;
  logic       out_free;

  assign out_free = !ov_r || out_tready;

  always_comb begin
    stat.start_match = (in_byte == start_r);
    stat.end_match   = (in_byte == end_r);
    stat.len_over    = ({1'b0, in_byte} > MAX9);
    stat.len_zero    = (count_r == 8'd0);
    stat.in_zero     = (in_byte == 8'd0);
    stat.data_last   = (({1'b0, idx_r} + 9'd1) >= {1'b0, count_r});
    stat.sum_ok      = (sum_r == csum_r);
    stat.rep_more    = (idx_r < count_r);
    stat.pend        = pend_r;
    stat.out_free    = out_free;
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load_len || cmd.end_clear) idx_nxt = 8'd0;
    else if (cmd.store_data || cmd.rep_issue) idx_nxt = idx_r + 8'd1;
    sum_nxt = sum_r;
    if (cmd.load_cmd) sum_nxt = in_byte;
    else if (cmd.store_data) sum_nxt = (sum_r + in_byte) & BYTE_MASK;
    pend_nxt = pend_r;
    if (cmd.rep_issue) pend_nxt = 1'b1;
    else if (cmd.rep_load) pend_nxt = 1'b0;
    ov_nxt = ov_r;
    if (cmd.emit || cmd.rep_load) ov_nxt = 1'b1;
    else if (out_tready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RST;
      end_r   <= END_RST;
      cmd_r   <= 8'd0;
      count_r <= 8'd0;
      idx_r   <= 8'd0;
      sum_r   <= 8'd0;
      csum_r  <= 8'd0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_START) start_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_END) end_r <= cfg_wdata;
      if (cmd.load_cmd) cmd_r <= in_byte;
      if (cmd.load_len) count_r <= in_byte;
      if (cmd.load_csum) csum_r <= in_byte;
      idx_r  <= idx_nxt;
      sum_r  <= sum_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // payload store, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.store_data) mem[idx_r[AW-1:0]] <= in_byte;
    if (cmd.rep_issue) begin
      rdata_r <= mem[idx_r[AW-1:0]];
      pidx_r  <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ost_r   <= cmd.emit_status;
      ocmd_r  <= cmd_r;
      olen_r  <= cmd.load_len ? in_byte : count_r;
      ohp_r   <= 1'b0;
      opb_r   <= 8'd0;
      oidx_r  <= 6'd0;
      olast_r <= 1'b1;
    end else if (cmd.rep_load) begin
      ost_r   <= ST_OK;
      ocmd_r  <= cmd_r;
      olen_r  <= count_r;
      ohp_r   <= 1'b1;
      opb_r   <= rdata_r;
      oidx_r  <= pidx_r[5:0];
      olast_r <= ((pidx_r + 8'd1) == count_r);
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_command     = ocmd_r;
  assign out_length      = olen_r;
  assign out_has_payload = ohp_r;
  assign out_payload     = opb_r;
  assign out_index       = oidx_r;
  assign out_last        = olast_r;

endmodule

`default_nettype wire

>>> rtl/core/marker_framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// marker_framed_packet_receiver
// one byte per cycle while framing, held off in replay and while a result
// waits at the length or end byte; a good frame replays its payload from the
// store at one word per cycle as results are taken, via a registered memory
// read and result register; error and empty frame results show in the cycle
// after the closing byte; synchronous active low reset, store is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module marker_framed_packet_receiver
  import mpr_pkg::*;
#(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // command, frame_length, payload_byte, byte_index
  output logic [2:0]       out_tuser,  // status, has_payload
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_stat_t   stat;
  status_t    o_status;
  logic [7:0] o_command, o_length, o_payload;
  logic [5:0] o_index;
  logic       o_hp;

  mpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mpr_dp #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_byte         (in_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .stat            (stat),
    .out_tready      (out_tready),
    .out_valid       (out_tvalid),
    .out_status      (o_status),
    .out_command     (o_command),
    .out_length      (o_length),
    .out_has_payload (o_hp),
    .out_payload     (o_payload),
    .out_index       (o_index),
    .out_last        (out_tlast)
  );

  assign out_tdata = {2'b00, o_index, o_payload, o_length, o_command};
  assign out_tuser = {o_hp, o_status};

`ifndef SYNTHESIS
  a_no_input_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rep_issue |-> !in_tready)
    else $error("input accepted during replay");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.rep_load) |-> !(out_tvalid && !out_tready))
    else $error("waiting result overwritten");

  a_mid_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tuser[2] && out_tuser[1:0] == ST_OK))
    else $error("non-final result without payload");

  a_error_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] != ST_OK) |-> (out_tlast && !out_tuser[2]))
    else $error("error result not single");
`endif

endmodule

`default_nettype wire

>>> tb/sv/marker_framed_packet_receiver_tb.sv
// ----------------------------------------------------------------------------
// marker_framed_packet_receiver_tb
// drives framed byte streams (good, empty, bad checksum, oversize length and
// wrong end marker frames mixed with line noise) into the receiver under four
// marker settings and three idle patterns, and checks every result word field
// by field against a behavioral frame decoder kept in the testbench
// ----------------------------------------------------------------------------
`default_nettype none

module marker_framed_packet_receiver_tb;
  import mpr_pkg::*;

  localparam int PAYLOAD_MAX = PAYLOAD_MAX_DEF;

  typedef struct packed {
    status_t    status;
    logic [7:0] command;
    logic [7:0] frame_length;
    logic       has_payload;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       last_word;
  } frame_res_t;

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    frame_res_t want;
  } dir_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;  // command, frame_length, payload_byte, byte_index
  logic [2:0]  out_tuser;  // status, has_payload
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = CFG_START;
  logic [7:0]  cfg_wdata  = 8'h00;

  marker_framed_packet_receiver #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // frame decoder state
  phase_t     fr_phase;
  logic [7:0] fr_cmd;
  logic [7:0] fr_len;
  logic [6:0] fr_idx;
  logic [7:0] fr_sum;
  logic [7:0] fr_csum;
  logic [7:0] fr_store [PAYLOAD_MAX];
  logic [7:0] start_mk;
  logic [7:0] end_mk;

  frame_res_t frame_res_q[$];
  dir_row_t   dir_tab[$];

  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int errors       = 0;
  int words_in     = 0;
  int res_seen     = 0;
  int res_ok       = 0;
  int res_csum     = 0;
  int res_len      = 0;
  int phase_words  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void decode_reset();
    fr_phase = PH_IDLE;
    fr_cmd   = '0;
    fr_len   = '0;
    fr_idx   = '0;
    fr_sum   = '0;
    fr_csum  = '0;
    start_mk = START_RST;
    end_mk   = END_RST;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    frame_res_t r;
    r = '0;
    case (fr_phase)
      PH_CMD: begin
        fr_cmd   = b;
        fr_sum   = b;
        fr_phase = PH_LEN;
      end
      PH_LEN: begin
        fr_len = b;
        fr_idx = '0;
        if (b > PAYLOAD_MAX) begin
          r.status       = ST_LEN;
          r.command      = fr_cmd;
          r.frame_length = b;
          r.last_word    = 1'b1;
          frame_res_q.push_back(r);
          fr_phase = PH_IDLE;
        end else if (b == 8'd0) begin
          fr_phase = PH_CSUM;
        end else begin
          fr_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        if (fr_idx < PAYLOAD_MAX) fr_store[fr_idx[5:0]] = b;
        fr_sum = fr_sum + b;
        fr_idx = fr_idx + 7'd1;
        if (fr_idx >= fr_len) fr_phase = PH_CSUM;
      end
      PH_CSUM: begin
        fr_csum  = b;
        fr_phase = PH_END;
      end
      PH_END: begin
        fr_phase = PH_IDLE;
        if (b == end_mk) begin
          r.command      = fr_cmd;
          r.frame_length = fr_len;
          r.last_word    = 1'b1;
          if (fr_sum != fr_csum) begin
            r.status = ST_CSUM;
            frame_res_q.push_back(r);
          end else if (fr_len == 8'd0) begin
            r.status = ST_OK;
            frame_res_q.push_back(r);
          end else begin
            for (int i = 0; i < fr_len && i < PAYLOAD_MAX; i++) begin
              r.status       = ST_OK;
              r.has_payload  = 1'b1;
              r.payload_byte = fr_store[i];
              r.byte_index   = i[5:0];
              r.last_word    = (i + 1 == fr_len);
              frame_res_q.push_back(r);
            end
          end
        end
        fr_idx = '0;
      end
      default: begin
        fr_phase = (b == start_mk) ? PH_CMD : PH_IDLE;
      end
    endcase
  endfunction

  // result side: random backpressure and checking
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else        out_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    frame_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      res_seen++;
      if (frame_res_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got tdata %0h tuser %0h",
                 $time, out_tdata, out_tuser);
      end else begin
        want = frame_res_q.pop_front();
        case (want.status)
          ST_OK:   res_ok++;
          ST_CSUM: res_csum++;
          default: res_len++;
        endcase
        check_field("status",       8'(want.status),       8'(out_tuser[1:0]));
        check_field("command",      want.command,          out_tdata[7:0]);
        check_field("frame_length", want.frame_length,     out_tdata[15:8]);
        check_field("has_payload",  8'(want.has_payload),  8'(out_tuser[2]));
        check_field("payload_byte", want.payload_byte,     out_tdata[23:16]);
        check_field("byte_index",   8'(want.byte_index),   8'(out_tdata[29:24]));
        check_field("last",         8'(want.last_word),    8'(out_tlast));
      end
    end
  end

  task automatic send_rx_byte(input logic [7:0] b, input bit typed = 1'b0,
                              input frame_res_t want = '0);
    int n0;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n0 = frame_res_q.size();
    decode_byte(b);
    if (typed) begin
      while (frame_res_q.size() > n0) void'(frame_res_q.pop_back());
      frame_res_q.push_back(want);
    end
    words_in++;
  endtask

  // hold off the sender until every result is out and the block has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    while (frame_res_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= CFG_END;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_we   <= 1'b0;
    start_mk = s;
    end_mk   = e;
  endtask

  function automatic logic [7:0] pick_byte();
    int k;
    k = $urandom_range(99);
    if (k < 10) return start_mk;
    if (k < 20) return end_mk;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_frame();
    int         kind;
    int         len;
    logic [7:0] cmd;
    logic [7:0] sum;
    logic [7:0] d;
    logic [7:0] noise;
    kind = $urandom_range(99);
    // line noise between frames, ignored while hunting
    repeat ($urandom_range(2)) begin
      noise = 8'($urandom_range(255));
      if (noise == start_mk) noise = ~noise;
      send_rx_byte(noise);
      phase_words++;
    end
    if (kind < 5) begin
      // stray byte that may itself open a broken frame
      send_rx_byte(pick_byte());
      phase_words++;
      return;
    end
    cmd = pick_byte();
    if (kind < 13)      len = $urandom_range(255, PAYLOAD_MAX + 1);
    else if (kind < 18) len = PAYLOAD_MAX;
    else if (kind < 28) len = 0;
    else                len = $urandom_range(8, 1);
    send_rx_byte(start_mk);
    send_rx_byte(cmd);
    send_rx_byte(8'(len));
    phase_words += 3;
    if (len > PAYLOAD_MAX) return;
    sum = cmd;
    for (int i = 0; i < len; i++) begin
      d = pick_byte();
      sum = sum + d;
      send_rx_byte(d);
    end
    if (kind >= 28 && kind < 38) sum = sum ^ 8'($urandom_range(255, 1));
    send_rx_byte(sum);
    if (kind >= 38 && kind < 46) send_rx_byte(end_mk ^ 8'($urandom_range(255, 1)));
    else                         send_rx_byte(end_mk);
    phase_words += len + 2;
  endtask

  task automatic random_phase(input int n_words);
    phase_words = 0;
    while (phase_words < n_words) send_frame();
  endtask

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    decode_reset();
    // reset markers: start AA, end 55
    dir_tab.push_back('{8'h00, 1'b0, '0});
    // oversize length
    dir_tab.push_back('{8'hAA, 1'b0, '0});
    dir_tab.push_back('{8'h3C, 1'b0, '0});
    dir_tab.push_back('{8'hFF, 1'b1, '{ST_LEN, 8'h3C, 8'hFF, 1'b0, 8'h00, 6'd0, 1'b1}});
    // empty good frame
    dir_tab.push_back('{8'hAA, 1'b0, '0});
    dir_tab.push_back('{8'h00, 1'b0, '0});
    dir_tab.push_back('{8'h00, 1'b0, '0});
    dir_tab.push_back('{8'h00, 1'b0, '0});
    dir_tab.push_back('{8'h55, 1'b1, '{ST_OK, 8'h00, 8'h00, 1'b0, 8'h00, 6'd0, 1'b1}});
    // checksum mismatch
    dir_tab.push_back('{8'hAA, 1'b0, '0});
    dir_tab.push_back('{8'hFF, 1'b0, '0});
    dir_tab.push_back('{8'h00, 1'b0, '0});
    dir_tab.push_back('{8'h00, 1'b0, '0});
    dir_tab.push_back('{8'h55, 1'b1, '{ST_CSUM, 8'hFF, 8'h00, 1'b0, 8'h00, 6'd0, 1'b1}});
    // wrong end marker, dropped
    dir_tab.push_back('{8'hAA, 1'b0, '0});
    dir_tab.push_back('{8'h01, 1'b0, '0});
    dir_tab.push_back('{8'h00, 1'b0, '0});
    dir_tab.push_back('{8'h01, 1'b0, '0});
    dir_tab.push_back('{8'h54, 1'b0, '0});
    // good frame with start marker value inside the payload
    dir_tab.push_back('{8'hAA, 1'b0, '0});
    dir_tab.push_back('{8'h12, 1'b0, '0});
    dir_tab.push_back('{8'h02, 1'b0, '0});
    dir_tab.push_back('{8'hAA, 1'b0, '0});
    dir_tab.push_back('{8'hFF, 1'b0, '0});
    dir_tab.push_back('{8'hBB, 1'b0, '0});
    dir_tab.push_back('{8'h55, 1'b0, '0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 20;
    dst_idle_pct = 61;
    foreach (dir_tab[i]) send_rx_byte(dir_tab[i].rx, dir_tab[i].typed, dir_tab[i].want);
    drain();
    set_markers(8'h00, 8'hFF);
    random_phase(95);

    drain();
    src_idle_pct = 61;
    dst_idle_pct = 20;
    set_markers(8'hFF, 8'h00);
    random_phase(95);

    drain();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    set_markers(8'($urandom_range(255)), 8'($urandom_range(255)));
    random_phase(95);

    drain();
    $display("sent %0d input words over reset, extreme and random marker settings",
             words_in);
    $display("checked %0d result words: %0d ok, %0d checksum errors, %0d length errors",
             res_seen, res_ok, res_csum, res_len);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
